[rtl/hmi_pkg.sv]
// Shared types, constants and arithmetic helpers for the Hu moment invariant core.
// Depends on nothing; the channel interfaces and the core refer to it by scoped names.
`default_nettype none

package hmi_pkg;

    localparam int EtaW = 32;
    localparam int InvW = 64;

    typedef logic signed [EtaW-1:0] eta_t;
    typedef logic signed [InvW-1:0] inv_t;
    typedef logic signed [67:0]     w68_t;
    typedef logic signed [135:0]    w136_t;

    // Round-half-up constants for dropping 30 and 60 fraction bits.
    localparam w136_t RND30 = w136_t'(136'd1 << 29);
    localparam w136_t RND60 = w136_t'(136'd1 << 59);

    localparam inv_t INV_MAX = {1'b0, {(InvW-1){1'b1}}};
    localparam inv_t INV_MIN = {1'b1, {(InvW-1){1'b0}}};

    // Four 35x35 partial products of a 68x68 signed product.
    typedef struct packed {
        logic signed [69:0] hh;
        logic signed [69:0] hl;
        logic signed [69:0] lh;
        logic signed [69:0] ll;
    } pp4_t;

    typedef struct packed {
        logic signed [32:0] d;
        logic signed [32:0] p;
        logic signed [32:0] q;
        logic signed [32:0] s;
        logic signed [33:0] m;
        logic signed [33:0] n;
        logic signed [31:0] e11;
    } s1_t;

    typedef struct packed {
        w68_t pp;
        w68_t qq;
        w68_t dd;
        w68_t ee4;
        w68_t mm;
        w68_t nn;
        w68_t mp;
        w68_t nq;
        w68_t np;
        w68_t mq;
        w68_t ep;
        logic signed [32:0] s;
        logic signed [32:0] d;
        logic signed [32:0] q;
    } s2_t;

    typedef struct packed {
        w68_t ga;
        w68_t gb;
        w68_t gd;
        w68_t mp;
        w68_t nq;
        w68_t np;
        w68_t mq;
        w68_t ep;
        logic signed [32:0] d;
        logic signed [32:0] q;
        inv_t o1;
        inv_t o2;
        inv_t o3;
        inv_t o4;
    } s3_t;

    typedef struct packed {
        pp4_t a;
        pp4_t b;
        pp4_t c;
        pp4_t e;
        pp4_t f;
        pp4_t g;
        inv_t o1;
        inv_t o2;
        inv_t o3;
        inv_t o4;
    } s4_t;

    typedef struct packed {
        w136_t a;
        w136_t b;
        w136_t c;
        w136_t e;
        w136_t f;
        w136_t g;
        inv_t  o1;
        inv_t  o2;
        inv_t  o3;
        inv_t  o4;
    } s5_t;

    typedef struct packed {
        w136_t v5;
        w136_t v6;
        w136_t v7;
        inv_t  o1;
        inv_t  o2;
        inv_t  o3;
        inv_t  o4;
    } s6_t;

    typedef struct packed {
        inv_t o1;
        inv_t o2;
        inv_t o3;
        inv_t o4;
        inv_t o5;
        inv_t o6;
        inv_t o7;
    } s7_t;

    function automatic w68_t mul34(input logic signed [33:0] a, input logic signed [33:0] b);
        w68_t r;
        r = a * b;
        return r;
    endfunction

    // Split both operands into a signed high half and an unsigned low half.
    function automatic pp4_t pp4_mul(input w68_t a, input w68_t b);
        logic signed [34:0] ah;
        logic signed [34:0] al;
        logic signed [34:0] bh;
        logic signed [34:0] bl;
        pp4_t r;
        ah = {a[67], a[67:34]};
        al = {1'b0, a[33:0]};
        bh = {b[67], b[67:34]};
        bl = {1'b0, b[33:0]};
        r.hh = ah * bh;
        r.hl = ah * bl;
        r.lh = al * bh;
        r.ll = al * bl;
        return r;
    endfunction

    function automatic w136_t pp4_sum(input pp4_t x);
        w136_t t0;
        w136_t t1;
        w136_t t2;
        w136_t t3;
        t0 = w136_t'($signed(x.hh)) <<< 68;
        t1 = w136_t'($signed(x.hl)) <<< 34;
        t2 = w136_t'($signed(x.lh)) <<< 34;
        t3 = w136_t'($signed(x.ll));
        return t0 + t1 + t2 + t3;
    endfunction

    function automatic inv_t sat64(input w136_t v);
        inv_t r;
        if (v[135:63] == {73{v[63]}}) begin
            r = v[63:0];
        end else if (v[135]) begin
            r = INV_MIN;
        end else begin
            r = INV_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/hmi_in_if.sv]
// Request channel carrying the seven normalized central moments of one region.
// Depends on hmi_pkg for the field type.
`default_nettype none

interface hmi_in_if;
    logic         valid;
    logic         ready;
    hmi_pkg::eta_t eta_20;
    hmi_pkg::eta_t eta_02;
    hmi_pkg::eta_t eta_11;
    hmi_pkg::eta_t eta_30;
    hmi_pkg::eta_t eta_12;
    hmi_pkg::eta_t eta_21;
    hmi_pkg::eta_t eta_03;

    modport source (output valid, eta_20, eta_02, eta_11, eta_30, eta_12, eta_21, eta_03,
                    input ready);
    modport sink   (input valid, eta_20, eta_02, eta_11, eta_30, eta_12, eta_21, eta_03,
                    output ready);
endinterface

`default_nettype wire

[rtl/hmi_out_if.sv]
// Request channel carrying Hu's seven invariants of one region.
// Depends on hmi_pkg for the field type.
`default_nettype none

interface hmi_out_if;
    logic         valid;
    logic         ready;
    hmi_pkg::inv_t inv_one;
    hmi_pkg::inv_t inv_two;
    hmi_pkg::inv_t inv_three;
    hmi_pkg::inv_t inv_four;
    hmi_pkg::inv_t inv_five;
    hmi_pkg::inv_t inv_six;
    hmi_pkg::inv_t inv_seven;

    modport source (output valid, inv_one, inv_two, inv_three, inv_four, inv_five, inv_six,
                    inv_seven, input ready);
    modport sink   (input valid, inv_one, inv_two, inv_three, inv_four, inv_five, inv_six,
                    inv_seven, output ready);
endinterface

`default_nettype wire

[rtl/hu_moment_invariants_core.sv]
// Hu moment invariant core: seven Q2.30 moments in, seven saturated Q4.60 invariants out.
// Depends on hmi_pkg, hmi_in_if and hmi_out_if.
//
// Usage:
//   moments    - sink channel; one request holds eta_20..eta_03 of one region.
//   invariants - source channel; one request holds inv_one..inv_seven for it.
//   Every accepted request yields exactly one result request, in order.
// Pipeline: seven register stages; the first loads at the accepting edge and the
//   last one is the output register, which drives the result onto invariants.
// Throughput: one request per cycle while invariants.ready stays high. Seven stages each hold one
//   item; the widest step is a 35x35 partial product, so the 136-bit products of
//   invariants five, six and seven are cut into partials and summed in later stages.
// Stall: a stage advances when it is empty or the stage behind it advances, so
//   bubbles collapse and moments.ready stays high until every stage is full and
//   invariants.ready is low. Nothing is lost or repeated under backpressure.
// Reset: rst_n clears all stage valid bits at once; data registers are not reset.
`default_nettype none

module hu_moment_invariants_core (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hmi_in_if.sink         moments,
    hmi_out_if.source      invariants
);

    localparam int NumStages = 7;

    logic [NumStages-1:0] vld_reg;
    logic [NumStages-1:0] vld_next;
    logic [NumStages-1:0] en;

    hmi_pkg::s1_t s1_reg, s1_next;
    hmi_pkg::s2_t s2_reg, s2_next;
    hmi_pkg::s3_t s3_reg, s3_next;
    hmi_pkg::s4_t s4_reg, s4_next;
    hmi_pkg::s5_t s5_reg, s5_next;
    hmi_pkg::s6_t s6_reg, s6_next;
    hmi_pkg::s7_t s7_reg, s7_next;

    // Advance a stage when it is empty or its successor advances.
    always_comb
    begin
        en[NumStages-1] = !vld_reg[NumStages-1] || invariants.ready;
        for (int k = NumStages - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next[0] = moments.valid;
        for (int k = 1; k < NumStages; k++)
        begin
            vld_next[k] = vld_reg[k-1];
        end
    end

    assign moments.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NumStages; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    // Stage 1: sums and differences of the moments.
    always_comb
    begin
        s1_next.d   = 33'(moments.eta_20) - 33'(moments.eta_02);
        s1_next.s   = 33'(moments.eta_20) + 33'(moments.eta_02);
        s1_next.p   = 33'(moments.eta_30) + 33'(moments.eta_12);
        s1_next.q   = 33'(moments.eta_21) + 33'(moments.eta_03);
        s1_next.m   = 34'(moments.eta_30) - 3 * 34'(moments.eta_12);
        s1_next.n   = 3 * 34'(moments.eta_21) - 34'(moments.eta_03);
        s1_next.e11 = moments.eta_11;
    end

    // Stage 2: all first-order products.
    always_comb
    begin
        s2_next.pp  = hmi_pkg::mul34(34'(s1_reg.p), 34'(s1_reg.p));
        s2_next.qq  = hmi_pkg::mul34(34'(s1_reg.q), 34'(s1_reg.q));
        s2_next.dd  = hmi_pkg::mul34(34'(s1_reg.d), 34'(s1_reg.d));
        s2_next.ee4 = hmi_pkg::mul34(34'(s1_reg.e11), 34'(s1_reg.e11)) <<< 2;
        s2_next.mm  = hmi_pkg::mul34(s1_reg.m, s1_reg.m);
        s2_next.nn  = hmi_pkg::mul34(s1_reg.n, s1_reg.n);
        s2_next.mp  = hmi_pkg::mul34(s1_reg.m, 34'(s1_reg.p));
        s2_next.nq  = hmi_pkg::mul34(s1_reg.n, 34'(s1_reg.q));
        s2_next.np  = hmi_pkg::mul34(s1_reg.n, 34'(s1_reg.p));
        s2_next.mq  = hmi_pkg::mul34(s1_reg.m, 34'(s1_reg.q));
        s2_next.ep  = hmi_pkg::mul34(34'(s1_reg.e11), 34'(s1_reg.p));
        s2_next.s   = s1_reg.s;
        s2_next.d   = s1_reg.d;
        s2_next.q   = s1_reg.q;
    end

    // Stage 3: bracket terms; invariants one to four are complete here.
    always_comb
    begin
        s3_next.ga = s2_reg.pp - 3 * s2_reg.qq;
        s3_next.gb = 3 * s2_reg.pp - s2_reg.qq;
        s3_next.gd = s2_reg.pp - s2_reg.qq;
        s3_next.mp = s2_reg.mp;
        s3_next.nq = s2_reg.nq;
        s3_next.np = s2_reg.np;
        s3_next.mq = s2_reg.mq;
        s3_next.ep = s2_reg.ep;
        s3_next.d  = s2_reg.d;
        s3_next.q  = s2_reg.q;
        s3_next.o1 = 64'(s2_reg.s) <<< 30;
        s3_next.o2 = hmi_pkg::sat64(hmi_pkg::w136_t'(s2_reg.dd + s2_reg.ee4));
        s3_next.o3 = hmi_pkg::sat64(hmi_pkg::w136_t'(s2_reg.mm + s2_reg.nn));
        s3_next.o4 = hmi_pkg::sat64(hmi_pkg::w136_t'(s2_reg.pp + s2_reg.qq));
    end

    // Stage 4: partial products of the wide multiplies.
    always_comb
    begin
        s4_next.a  = hmi_pkg::pp4_mul(s3_reg.mp, s3_reg.ga);
        s4_next.b  = hmi_pkg::pp4_mul(s3_reg.nq, s3_reg.gb);
        s4_next.c  = hmi_pkg::pp4_mul(s3_reg.np, s3_reg.ga);
        s4_next.e  = hmi_pkg::pp4_mul(s3_reg.mq, s3_reg.gb);
        s4_next.f  = hmi_pkg::pp4_mul(hmi_pkg::w68_t'(s3_reg.d), s3_reg.gd);
        s4_next.g  = hmi_pkg::pp4_mul(s3_reg.ep, hmi_pkg::w68_t'(s3_reg.q));
        s4_next.o1 = s3_reg.o1;
        s4_next.o2 = s3_reg.o2;
        s4_next.o3 = s3_reg.o3;
        s4_next.o4 = s3_reg.o4;
    end

    // Stage 5: fold the partials of each product.
    always_comb
    begin
        s5_next.a  = hmi_pkg::pp4_sum(s4_reg.a);
        s5_next.b  = hmi_pkg::pp4_sum(s4_reg.b);
        s5_next.c  = hmi_pkg::pp4_sum(s4_reg.c);
        s5_next.e  = hmi_pkg::pp4_sum(s4_reg.e);
        s5_next.f  = hmi_pkg::pp4_sum(s4_reg.f);
        s5_next.g  = hmi_pkg::pp4_sum(s4_reg.g);
        s5_next.o1 = s4_reg.o1;
        s5_next.o2 = s4_reg.o2;
        s5_next.o3 = s4_reg.o3;
        s5_next.o4 = s4_reg.o4;
    end

    // Stage 6: combine products and add the rounding half.
    always_comb
    begin
        s6_next.v5 = s5_reg.a + s5_reg.b + hmi_pkg::RND60;
        s6_next.v7 = s5_reg.c - s5_reg.e + hmi_pkg::RND60;
        s6_next.v6 = s5_reg.f + ($signed(s5_reg.g) <<< 2) + hmi_pkg::RND30;
        s6_next.o1 = s5_reg.o1;
        s6_next.o2 = s5_reg.o2;
        s6_next.o3 = s5_reg.o3;
        s6_next.o4 = s5_reg.o4;
    end

    // Stage 7 (output register): drop fraction bits and saturate.
    always_comb
    begin
        s7_next.o1 = s6_reg.o1;
        s7_next.o2 = s6_reg.o2;
        s7_next.o3 = s6_reg.o3;
        s7_next.o4 = s6_reg.o4;
        s7_next.o5 = hmi_pkg::sat64($signed(s6_reg.v5) >>> 60);
        s7_next.o6 = hmi_pkg::sat64($signed(s6_reg.v6) >>> 30);
        s7_next.o7 = hmi_pkg::sat64($signed(s6_reg.v7) >>> 60);
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) s1_reg <= s1_next;
        if (en[1]) s2_reg <= s2_next;
        if (en[2]) s3_reg <= s3_next;
        if (en[3]) s4_reg <= s4_next;
        if (en[4]) s5_reg <= s5_next;
        if (en[5]) s6_reg <= s6_next;
        if (en[6]) s7_reg <= s7_next;
    end

    assign invariants.valid     = vld_reg[NumStages-1];
    assign invariants.inv_one   = s7_reg.o1;
    assign invariants.inv_two   = s7_reg.o2;
    assign invariants.inv_three = s7_reg.o3;
    assign invariants.inv_four  = s7_reg.o4;
    assign invariants.inv_five  = s7_reg.o5;
    assign invariants.inv_six   = s7_reg.o6;
    assign invariants.inv_seven = s7_reg.o7;

    // Refuse new requests only when every stage is full and the output stalls.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !moments.ready |-> (vld_reg == '1 && !invariants.ready))
        else $error("input stalled with a free stage");

    // An accepted request occupies the first stage on the next cycle.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (moments.valid && moments.ready) |=> vld_reg[0])
        else $error("accepted request dropped at entry");

    // Sums of squares never come out negative.
    a_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        invariants.valid |-> (!invariants.inv_two[63] && !invariants.inv_three[63]
                              && !invariants.inv_four[63]))
        else $error("sum-of-squares invariant negative");

endmodule

`default_nettype wire

[verif/tb.sv]
// Self-checking bench for hu_moment_invariants_core: directed and random moment sets,
// with the exact invariants predicted at 256-bit width and compared per field.
// Depends on hmi_pkg, hmi_in_if, hmi_out_if and the core.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        hmi_pkg::eta_t e20;
        hmi_pkg::eta_t e02;
        hmi_pkg::eta_t e11;
        hmi_pkg::eta_t e30;
        hmi_pkg::eta_t e12;
        hmi_pkg::eta_t e21;
        hmi_pkg::eta_t e03;
    } moments_t;

    typedef struct packed {
        hmi_pkg::inv_t v1;
        hmi_pkg::inv_t v2;
        hmi_pkg::inv_t v3;
        hmi_pkg::inv_t v4;
        hmi_pkg::inv_t v5;
        hmi_pkg::inv_t v6;
        hmi_pkg::inv_t v7;
    } hu_set_t;

    typedef logic signed [255:0] exact_t;

    logic clk;
    logic rst_n;

    hmi_in_if  moments_ch();
    hmi_out_if hu_ch();

    hu_moment_invariants_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .moments    (moments_ch.sink),
        .invariants (hu_ch.source)
    );

    moments_t pending_moments[$];
    hu_set_t  expected_hu[$];
    int       mismatch_count;
    int       gap_left;
    int       stall_left;
    int       hold_off_left;
    bit       hold_off_seen;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Round away k fraction bits (ties up), then saturate to 64 bits.
    function automatic hmi_pkg::inv_t round_saturate(input exact_t v, input int k);
        exact_t s;
        if (k > 0)
        begin
            v = v + (exact_t'(1) <<< (k - 1));
        end
        s = v >>> k;
        if (s > exact_t'(hmi_pkg::INV_MAX))
        begin
            return hmi_pkg::INV_MAX;
        end
        if (s < exact_t'(hmi_pkg::INV_MIN))
        begin
            return hmi_pkg::INV_MIN;
        end
        return s[63:0];
    endfunction

    function automatic hu_set_t hu_invariants(input moments_t x);
        exact_t e20, e02, e11, e30, e12, e21, e03;
        exact_t d, p, q, m, n, pp, qq, ga, gb;
        hu_set_t r;
        e20 = exact_t'(x.e20);
        e02 = exact_t'(x.e02);
        e11 = exact_t'(x.e11);
        e30 = exact_t'(x.e30);
        e12 = exact_t'(x.e12);
        e21 = exact_t'(x.e21);
        e03 = exact_t'(x.e03);
        d  = e20 - e02;
        p  = e30 + e12;
        q  = e21 + e03;
        m  = e30 - 3 * e12;
        n  = 3 * e21 - e03;
        pp = p * p;
        qq = q * q;
        ga = pp - 3 * qq;
        gb = 3 * pp - qq;
        // Invariant one is Q2.30 scaled up to 60 fraction bits.
        r.v1 = round_saturate((e20 + e02) <<< 30, 0);
        r.v2 = round_saturate(d * d + 4 * e11 * e11, 0);
        r.v3 = round_saturate(m * m + n * n, 0);
        r.v4 = round_saturate(pp + qq, 0);
        r.v5 = round_saturate(m * p * ga + n * q * gb, 60);
        r.v6 = round_saturate(d * (pp - qq) + 4 * e11 * p * q, 30);
        r.v7 = round_saturate(n * p * ga - m * q * gb, 60);
        return r;
    endfunction

    // Mix of extremes, small values, mid-range values and full-range values per field.
    function automatic hmi_pkg::eta_t random_eta();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return hmi_pkg::eta_t'($urandom_range(0, 4)) - 2;
            3, 4, 5: return hmi_pkg::eta_t'($signed($urandom_range(0, 32'h7FFF_FFFF)) >>> 1)
                             - (32'sh1 <<< 29);
            default: return hmi_pkg::eta_t'($urandom);
        endcase
    endfunction

    task automatic queue_moments(input moments_t x);
        pending_moments.push_back(x);
    endtask

    // Short gaps mostly, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Source: drive the next request from the queue, with random gaps between them.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            moments_ch.valid  <= 1'b0;
            moments_ch.eta_20 <= '0;
            moments_ch.eta_02 <= '0;
            moments_ch.eta_11 <= '0;
            moments_ch.eta_30 <= '0;
            moments_ch.eta_12 <= '0;
            moments_ch.eta_21 <= '0;
            moments_ch.eta_03 <= '0;
            gap_left          <= 0;
        end
        else
        begin
            if (moments_ch.valid && moments_ch.ready)
            begin
                // Predict at acceptance so ordering matches the pipe.
                expected_hu.push_back(hu_invariants({moments_ch.eta_20, moments_ch.eta_02,
                    moments_ch.eta_11, moments_ch.eta_30, moments_ch.eta_12,
                    moments_ch.eta_21, moments_ch.eta_03}));
            end
            if (!moments_ch.valid || moments_ch.ready)
            begin
                if (gap_left > 0)
                begin
                    moments_ch.valid <= 1'b0;
                    gap_left         <= gap_left - 1;
                end
                else if (pending_moments.size() > 0)
                begin
                    moments_t x;
                    x = pending_moments.pop_front();
                    moments_ch.valid  <= 1'b1;
                    moments_ch.eta_20 <= x.e20;
                    moments_ch.eta_02 <= x.e02;
                    moments_ch.eta_11 <= x.e11;
                    moments_ch.eta_30 <= x.e30;
                    moments_ch.eta_12 <= x.e12;
                    moments_ch.eta_21 <= x.e21;
                    moments_ch.eta_03 <= x.e03;
                    gap_left          <= idle_length();
                end
                else
                begin
                    moments_ch.valid <= 1'b0;
                end
            end
        end
    end

    // One long result-side hold-off, once results are due and over 600 requests wait.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_left <= 0;
            hold_off_seen <= 1'b0;
        end
        else if (!hold_off_seen && expected_hu.size() > 0 && pending_moments.size() > 600)
        begin
            hold_off_left <= 60;
            hold_off_seen <= 1'b1;
        end
        else if (hold_off_left > 0)
        begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    // Sink: random stalls, then compare each accepted result with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hu_ch.ready    <= 1'b0;
            stall_left     <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            if (hu_ch.valid && hu_ch.ready)
            begin
                hu_set_t got;
                hu_set_t want;
                int      bad;
                bad = 0;
                got = {hu_ch.inv_one, hu_ch.inv_two, hu_ch.inv_three, hu_ch.inv_four,
                       hu_ch.inv_five, hu_ch.inv_six, hu_ch.inv_seven};
                if (expected_hu.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("ERROR: unexpected result %h", got);
                    end
                    bad = 1;
                end
                else
                begin
                    want = expected_hu.pop_front();
                    for (int i = 0; i < 7; i++)
                    begin
                        if (got[i*64 +: 64] !== want[i*64 +: 64])
                        begin
                            if (mismatch_count + bad < 10)
                            begin
                                $display("ERROR: invariant %0d expected %h actual %h",
                                         7 - i, want[i*64 +: 64], got[i*64 +: 64]);
                            end
                            bad = bad + 1;
                        end
                    end
                end
                mismatch_count <= mismatch_count + bad;
            end
            if (hold_off_left > 0)
            begin
                hu_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                hu_ch.ready <= 1'b0;
                stall_left  <= stall_left - 1;
            end
            else
            begin
                hu_ch.ready <= 1'b1;
                stall_left  <= idle_length();
            end
        end
    end

    initial
    begin
        moments_t x;
        moments_ch.valid = 1'b0;
        hu_ch.ready      = 1'b0;
        rst_n            = 1'b0;

        // Directed: zeros, all-max, all-min, alternating extremes, unit values.
        queue_moments('0);
        queue_moments({7{32'sh7FFF_FFFF}});
        queue_moments({7{32'sh8000_0000}});
        queue_moments({32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF});
        queue_moments({32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
        queue_moments({7{32'sh4000_0000}});
        queue_moments({7{-32'sh4000_0000}});
        queue_moments({7{32'sh1}});
        queue_moments({7{-32'sh1}});
        // Rounding of invariant six: odd small values.
        queue_moments({32'sh1, 32'sh0, 32'sh0, 32'sh1, 32'sh0, 32'sh0, 32'sh0});
        queue_moments({32'sh0, 32'sh0, 32'sh1, 32'sh1, 32'sh0, 32'sh1, 32'sh0});
        // Single-field minimum values.
        for (int f = 0; f < 7; f++)
        begin
            x = '0;
            x[f*32 +: 32] = 32'sh8000_0000;
            queue_moments(x);
        end

        for (int i = 0; i < 1250; i++)
        begin
            x = {random_eta(), random_eta(), random_eta(), random_eta(),
                 random_eta(), random_eta(), random_eta()};
            queue_moments(x);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_moments.size() == 0 && !moments_ch.valid);
        wait (expected_hu.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
